// File: rtl/rotation_matrix_to_euler_unit_defines.svh
// assertion macros shared by the rotation matrix to euler rtl
`ifndef ROTATION_MATRIX_TO_EULER_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_UNIT_DEFINES_SVH
// implication checked on every rising edge outside reset
`define RME_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
// implication whose consequent is checked in the next cycle
`define RME_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// File: rtl/rme_pkg.sv
// shared constants and types for the rotation matrix to euler unit
package rme_pkg;
	localparam int CordicStagesDef = 16;
	localparam int TableLen = 24;
	localparam int MatW = 16;
	localparam int AngW = 15;
	localparam int ThrW = 15;
	localparam int SqW = 32;
	localparam int RootW = 16;
	localparam int SqrtSteps = 16;
	localparam int CorW = 34;
	localparam int ZW = 32;
	localparam int OutShift = 15;
	localparam logic signed [AngW-1:0] HalfPiQ13 = 15'sd12868;
	localparam logic [0:0] RegThreshold = 1'b0;

	typedef logic signed [MatW-1:0] mat_t;
	typedef logic signed [AngW-1:0] ang_t;

	// one lane of cordic work: x, y, accumulated angle and zero-denominator result
	typedef struct packed {
		logic signed [CorW-1:0] x;
		logic signed [CorW-1:0] y;
		logic signed [ZW-1:0]   z;
		logic                   den_zero;
		ang_t                   zero_res;
	} cor_lane_t;

	function automatic logic signed [ZW-1:0] atan_entry(input int idx);
		logic signed [ZW-1:0] t [TableLen];
		t = '{32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
			32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109, 32'sd1048571,
			32'sd524287, 32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
			32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
			32'sd256, 32'sd128, 32'sd64, 32'sd32};
		return t[idx];
	endfunction
endpackage

// File: rtl/rme_sqrt_cell.sv
// one restoring square root step: one root bit per cell
module rme_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [rme_pkg::SqW:0]     rem_i,
	input  logic [rme_pkg::RootW-1:0] root_i,
	output logic [rme_pkg::SqW:0]     rem_o,
	output logic [rme_pkg::RootW-1:0] root_o
);
	import rme_pkg::*;
	localparam int Sh = 2 * (RootW - 1 - STEP);
	logic [SqW+1:0] trial;
	logic [SqW+1:0] rem_w;
	logic [RootW-1:0] bitv;
	always_comb begin
		bitv = RootW'(1) << (RootW - 1 - STEP);
		// (2*root + bit) * bit = trial subtrahend, root holds bits above
		trial = ((SqW+2)'(root_i) << (RootW - STEP)) + ((SqW+2)'(1) << Sh);
		rem_w = (SqW+2)'(rem_i);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_w >= trial) begin
				rem_o  <= (SqW+1)'(rem_w - trial);
				root_o <= root_i | bitv;
			end else begin
				rem_o  <= rem_i;
				root_o <= root_i;
			end
		end
	end
endmodule

// File: rtl/rme_cordic_cell.sv
// one cordic vectoring iteration for one lane, registered
module rme_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  rme_pkg::cor_lane_t lane_i,
	output rme_pkg::cor_lane_t lane_o
);
	import rme_pkg::*;
	logic signed [CorW-1:0] xs, ys;
	always_comb begin
		xs = lane_i.x >>> STEP;
		ys = lane_i.y >>> STEP;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lane_o.den_zero <= lane_i.den_zero;
			lane_o.zero_res <= lane_i.zero_res;
			if (!lane_i.y[CorW-1]) begin
				lane_o.x <= lane_i.x + ys;
				lane_o.y <= lane_i.y - xs;
				lane_o.z <= lane_i.z + atan_entry(STEP);
			end else begin
				lane_o.x <= lane_i.x - ys;
				lane_o.y <= lane_i.y + xs;
				lane_o.z <= lane_i.z - atan_entry(STEP);
			end
		end
	end
endmodule

// File: rtl/rotation_matrix_to_euler_unit.sv
// pipeline: squares register, sqrt cells, cordic seed register, cordic cells, output register
// the squares register on the transfer edge itself; cordic stages above 24 act as 24
// throughput: one matrix per cycle while the pipe advances; a chain of sqrt cells then a chain of cordic cells
// the whole pipe advances when the output register is free or being taken
// reset clears valid bits and sets singular_threshold to 1
// payload registers are not reset
module rotation_matrix_to_euler_unit #(
	parameter int CORDIC_STAGES = rme_pkg::CordicStagesDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  rme_pkg::mat_t m_c0_r0,
	input  rme_pkg::mat_t m_c1_r0,
	input  rme_pkg::mat_t m_c2_r0,
	input  rme_pkg::mat_t m_c2_r1,
	input  rme_pkg::mat_t m_c2_r2,
	input  rme_pkg::mat_t m_c1_r2,
	input  rme_pkg::mat_t m_c1_r1,
	output logic out_valid,
	input  logic out_stall,
	output rme_pkg::ang_t angle_x,
	output rme_pkg::ang_t angle_y,
	output rme_pkg::ang_t angle_z,
	output logic singular
);
	import rme_pkg::*;
	`include "rotation_matrix_to_euler_unit_defines.svh"

	localparam int NC = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
	localparam int SqLat = SqrtSteps + 1;
	localparam int Lat = SqLat + 1 + NC;

	logic [ThrW-1:0] thr_q;
	logic adv;
	logic [Lat-1:0] vld_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegThreshold) ? {17'd0, thr_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThrW'(1);
		end else if (psel && penable && pwrite && paddr[2] == RegThreshold) begin
			thr_q <= pwdata[ThrW-1:0];
		end
	end

	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_q <= {vld_q[Lat-2:0], in_valid};
			out_valid <= vld_q[Lat-1];
		end
	end

	// stage 1: squares
	logic [SqW-1:0] sq0_s1, sq1_s1;
	mat_t c0_s1, c1_s1, c2r0_s1, c2r1_s1, c2r2_s1, c1r2_s1, c1r1_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			sq0_s1 <= SqW'(m_c0_r0 * m_c0_r0);
			sq1_s1 <= SqW'(m_c1_r0 * m_c1_r0);
			c0_s1 <= m_c0_r0; c1_s1 <= m_c1_r0; c2r0_s1 <= m_c2_r0;
			c2r1_s1 <= m_c2_r1; c2r2_s1 <= m_c2_r2; c1r2_s1 <= m_c1_r2; c1r1_s1 <= m_c1_r1;
		end
	end

	// sqrt chain, matrix elements ride alongside
	logic [SqW:0] rem [SqrtSteps+1];
	logic [RootW-1:0] root [SqrtSteps+1];
	mat_t dly [SqrtSteps+1][7];
	assign rem[0] = (SqW+1)'(sq0_s1) + (SqW+1)'(sq1_s1);
	assign root[0] = '0;
	assign dly[0] = '{c0_s1, c1_s1, c2r0_s1, c2r1_s1, c2r2_s1, c1r2_s1, c1r1_s1};
	for (genvar g = 0; g < SqrtSteps; g++) begin : g_sq
		rme_sqrt_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(adv), .rem_i(rem[g]), .root_i(root[g]),
			.rem_o(rem[g+1]), .root_o(root[g+1])
		);
		always_ff @(posedge clk) begin
			if (adv) dly[g+1] <= dly[g];
		end
	end

	// branch select and cordic seeding
	logic [RootW-1:0] sy;
	logic sing_w;
	logic signed [MatW+1:0] nx, dx, ny, dy, nz, dz;
	cor_lane_t seed [3];
	logic sing_s2;
	assign sy = root[SqrtSteps];
	assign sing_w = ({1'b0, sy} < (RootW+1)'(thr_q));

	function automatic cor_lane_t mk_lane(input logic signed [MatW+1:0] n,
		input logic signed [MatW+1:0] d);
		cor_lane_t l;
		logic signed [MatW+1:0] an, ad;
		ad = d[MatW+1] ? -d : d;
		an = d[MatW+1] ? -n : n;
		l.x = CorW'(ad) <<< 14;
		l.y = CorW'(an) <<< 14;
		l.z = '0;
		l.den_zero = (d == '0);
		l.zero_res = (n > 0) ? HalfPiQ13 : ((n < 0) ? -HalfPiQ13 : ang_t'(0));
		return l;
	endfunction

	always_comb begin
		mat_t [6:0] e;
		e = '{dly[SqrtSteps][0], dly[SqrtSteps][1], dly[SqrtSteps][2],
			dly[SqrtSteps][3], dly[SqrtSteps][4], dly[SqrtSteps][5], dly[SqrtSteps][6]};
		// e[6]=c0r0 e[5]=c1r0 e[4]=c2r0 e[3]=c2r1 e[2]=c2r2 e[1]=c1r2 e[0]=c1r1
		ny = -(MatW+2)'(e[4]);
		dy = (MatW+2)'(signed'({1'b0, sy}));
		if (sing_w) begin
			nx = -(MatW+2)'(e[1]); dx = (MatW+2)'(e[0]);
		end else begin
			nx = (MatW+2)'(e[3]); dx = (MatW+2)'(e[2]);
		end
		nz = (MatW+2)'(e[5]); dz = (MatW+2)'(e[6]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seed[0] <= mk_lane(nx, dx);
			seed[1] <= mk_lane(ny, dy);
			seed[2] <= mk_lane(nz, dz);
			sing_s2 <= sing_w;
		end
	end

	cor_lane_t lane [3][NC+1];
	logic sflag [NC+1];
	assign sflag[0] = sing_s2;
	for (genvar k = 0; k < 3; k++) begin : g_ln
		assign lane[k][0] = seed[k];
		for (genvar s = 0; s < NC; s++) begin : g_st
			rme_cordic_cell #(.STEP(s)) u_cell (
				.clk(clk), .en(adv), .lane_i(lane[k][s]), .lane_o(lane[k][s+1])
			);
		end
	end
	for (genvar s = 0; s < NC; s++) begin : g_sf
		always_ff @(posedge clk) begin
			if (adv) sflag[s+1] <= sflag[s];
		end
	end

	function automatic ang_t fin(input cor_lane_t l);
		logic signed [ZW-1:0] z, r, az;
		z = l.z;
		az = z[ZW-1] ? -z : z;
		r = (az + (ZW'(1) <<< (OutShift-1))) >>> OutShift;
		if (z[ZW-1]) r = -r;
		if (r > ZW'(HalfPiQ13)) r = ZW'(HalfPiQ13);
		if (r < -ZW'(HalfPiQ13)) r = -ZW'(HalfPiQ13);
		return l.den_zero ? l.zero_res : AngW'(r);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_x <= fin(lane[0][NC]);
			angle_y <= fin(lane[1][NC]);
			angle_z <= sflag[NC] ? ang_t'(0) : fin(lane[2][NC]);
			singular <= sflag[NC];
		end
	end

	`RME_ASSERT_IMPL(a_stall_blocks, out_valid && out_stall, in_stall)
	`RME_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(angle_x))
	`RME_ASSERT_IMPL(a_sing_z, out_valid && singular, angle_z == '0)
endmodule

// File: tb/rotation_matrix_to_euler_checker.sv
// checker for the rotation matrix to euler unit: predicts angles and compares results
module rotation_matrix_to_euler_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	input  logic in_valid,
	input  logic in_stall,
	input  rme_pkg::mat_t m_c0_r0,
	input  rme_pkg::mat_t m_c1_r0,
	input  rme_pkg::mat_t m_c2_r0,
	input  rme_pkg::mat_t m_c2_r1,
	input  rme_pkg::mat_t m_c2_r2,
	input  rme_pkg::mat_t m_c1_r2,
	input  rme_pkg::mat_t m_c1_r1,
	input  logic out_valid,
	input  logic out_stall,
	input  rme_pkg::ang_t angle_x,
	input  rme_pkg::ang_t angle_y,
	input  rme_pkg::ang_t angle_z,
	input  logic singular,
	output int fail_count,
	output int pending_angles,
	output int angle_count,
	output int singular_count
);
	import rme_pkg::*;

	typedef struct packed {
		ang_t ax;
		ang_t ay;
		ang_t az;
		logic sing;
	} euler_t;

	localparam int Stages = CordicStagesDef;
	localparam longint HalfPi = 12868;

	euler_t angle_queue[$];
	logic [ThrW-1:0] thresh_shadow;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint n);
		longint r;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= n)
				r = r + (64'sd1 << b);
		end
		return r;
	endfunction

	function automatic longint atan_of_ratio(longint num, longint den);
		longint x, y, z, xs, ys, r;
		longint tab [24];
		tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
			4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
			16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
		if (den == 0)
			return (num > 0) ? HalfPi : (num < 0) ? -HalfPi : 0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		x = den <<< 14;
		y = num <<< 14;
		z = 0;
		for (int i = 0; i < ((Stages > 24) ? 24 : Stages); i++) begin
			xs = shr_floor(x, i);
			ys = shr_floor(y, i);
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + tab[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - tab[i];
			end
		end
		if (z >= 0)
			r = (z + 16384) >>> 15;
		else
			r = -((-z + 16384) >>> 15);
		if (r > HalfPi)
			r = HalfPi;
		if (r < -HalfPi)
			r = -HalfPi;
		return r;
	endfunction

	function automatic euler_t predict_euler(longint a00, longint a10, longint a20,
			longint a21, longint a22, longint a12, longint a11, logic [ThrW-1:0] thr);
		euler_t e;
		longint sy;
		sy = root_floor(a00 * a00 + a10 * a10);
		e.ay = ang_t'(atan_of_ratio(-a20, sy));
		if (sy >= longint'(thr)) begin
			e.ax = ang_t'(atan_of_ratio(a21, a22));
			e.az = ang_t'(atan_of_ratio(a10, a00));
			e.sing = 1'b0;
		end else begin
			e.ax = ang_t'(atan_of_ratio(-a12, a11));
			e.az = '0;
			e.sing = 1'b1;
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		euler_t want;
		int errs;
		if (!arst_n) begin
			thresh_shadow <= ThrW'(1);
			angle_queue.delete();
			fail_count <= 0;
			pending_angles <= 0;
			angle_count <= 0;
			singular_count <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready && paddr[2] == RegThreshold)
				thresh_shadow <= pwdata[ThrW-1:0];
			if (in_valid && !in_stall)
				angle_queue.push_back(predict_euler(m_c0_r0, m_c1_r0, m_c2_r0, m_c2_r1,
					m_c2_r2, m_c1_r2, m_c1_r1, thresh_shadow));
			if (out_valid && !out_stall) begin
				angle_count <= angle_count + 1;
				if (singular)
					singular_count <= singular_count + 1;
				if (angle_queue.size() == 0) begin
					$error("result transfer with no matrix outstanding");
					errs++;
				end else begin
					want = angle_queue.pop_front();
					if (angle_x !== want.ax) begin
						$error("angle_x expected %0d got %0d", want.ax, angle_x);
						errs++;
					end
					if (angle_y !== want.ay) begin
						$error("angle_y expected %0d got %0d", want.ay, angle_y);
						errs++;
					end
					if (angle_z !== want.az) begin
						$error("angle_z expected %0d got %0d", want.az, angle_z);
						errs++;
					end
					if (singular !== want.sing) begin
						$error("singular expected %0d got %0d", want.sing, singular);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			pending_angles <= angle_queue.size();
		end
	end
endmodule

// File: tb/rotation_matrix_to_euler_unit_tb.sv
// testbench top for the rotation matrix to euler unit: stimulus, register writes, verdict
module rotation_matrix_to_euler_unit_tb;
	import rme_pkg::*;

	localparam int Latency = 2 + 16 + 1 + CordicStagesDef + 1;
	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic in_valid, in_stall, out_valid, out_stall, singular;
	mat_t m_c0_r0, m_c1_r0, m_c2_r0, m_c2_r1, m_c2_r2, m_c1_r2, m_c1_r1;
	ang_t angle_x, angle_y, angle_z;
	int fail_count, pending_angles, angle_count, singular_count;
	int cycles;
	logic stall_runs;

	rotation_matrix_to_euler_unit dut (.*);

	rotation_matrix_to_euler_checker chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// cycle limit guards against a hung handshake
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("timeout after %0d cycles", cycles);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver stalls: short mostly, sometimes long, sometimes none at all
	initial begin
		int n;
		out_stall = 1'b0;
		stall_runs = 1'b1;
		forever begin
			@(posedge clk);
			if (!stall_runs) begin
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 9) < 3) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
				@(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
				if ($urandom_range(0, 49) == 0)
					repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	task automatic write_threshold(input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {RegThreshold, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_results();
		@(posedge clk);
		while (pending_angles != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	// one matrix transfer, then an optional gap
	task automatic send_matrix(input mat_t a00, a10, a20, a21, a22, a12, a11);
		in_valid <= 1'b1;
		m_c0_r0 <= a00;
		m_c1_r0 <= a10;
		m_c2_r0 <= a20;
		m_c2_r1 <= a21;
		m_c2_r2 <= a22;
		m_c1_r2 <= a12;
		m_c1_r1 <= a11;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 15) == 0) ? $urandom_range(8, 30)
				: $urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	function automatic mat_t pick_elem();
		case ($urandom_range(0, 7))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return 16'sd16384;
			4: return -16'sd16384;
			5: return mat_t'($urandom_range(0, 15)) - 16'sd8;
			default: return mat_t'($urandom);
		endcase
	endfunction

	task automatic random_block(input int count);
		int s, c;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) != 0) begin
				// near-rotation: cos/sin-like pair in range, other elements from pick_elem
				s = $urandom_range(0, 32768) - 16384;
				c = (($urandom_range(0, 1) == 1) ? 1 : -1)
					* $rtoi($sqrt(268435456.0 - s * s));
				send_matrix(mat_t'(c), mat_t'(s), pick_elem(), pick_elem(), pick_elem(),
					pick_elem(), pick_elem());
			end else begin
				send_matrix(pick_elem(), pick_elem(), pick_elem(), pick_elem(), pick_elem(),
					pick_elem(), pick_elem());
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [31:0] thr_list [6];
		thr_list = '{32'd0, 32'd32767, 32'd16384, 32'hFFFF_8123, 32'd300, 32'd1};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		{m_c0_r0, m_c1_r0, m_c2_r0, m_c2_r1, m_c2_r2, m_c1_r2, m_c1_r1} = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero denominators, gimbal lock at reset threshold
		send_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_matrix(16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd0, -16'sd7, 16'sd0);
		send_matrix(16'sd0, 16'sd0, -16'sd5, 16'sd3, 16'sd0, 16'sd7, 16'sd0);
		send_matrix(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
		send_matrix(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768, -16'sd32768);
		send_matrix(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767);
		send_matrix(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
			-16'sd32768, 16'sd32767);
		send_matrix(16'sd0, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1);
		send_matrix(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, -16'sd1, 16'sd0, 16'sd0);
		send_matrix(-16'sd1, 16'sd0, 16'sd16384, 16'sd0, 16'sd1, -16'sd16384, -16'sd1);
		send_matrix(16'sd11585, -16'sd11585, 16'sd0, -16'sd11585, 16'sd11585, 16'sd3, 16'sd3);
		random_block(200);

		foreach (thr_list[t]) begin
			drain_results();
			write_threshold(thr_list[t]);
			if (t == 2)
				stall_runs = 1'b0;
			if (t == 3)
				stall_runs = 1'b1;
			random_block(280);
		end

		drain_results();
		$display("covered %0d result transfers, %0d in the gimbal-lock branch,",
			angle_count, singular_count);
		$display("over six threshold settings including 0 and 32767");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
